### hdl/bsal_pkg.sv
package bsal_pkg;

  // Default list depth and record field widths
  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 8;
  localparam int PAY_W     = 32;

  // Operation codes
  typedef enum logic [2:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_LAST   = 3'd1,
    OP_INS_AT     = 3'd2,
    OP_INS_SORTED = 3'd3,
    OP_DEL_FIRST  = 3'd4,
    OP_DEL_LAST   = 3'd5,
    OP_DEL_AT     = 3'd6,
    OP_READ_AT    = 3'd7
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  // Per-cell load control for one update
  typedef struct packed {
    logic take_new;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

### hdl/bsal_cell.sv
module bsal_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                       clk,
  input  bsal_pkg::cell_ctl_t        ctl,
  input  logic [CW-1:0]              count,
  input  logic [bsal_pkg::KEY_W-1:0] new_key,
  input  logic [bsal_pkg::PAY_W-1:0] new_pay,
  input  logic [bsal_pkg::KEY_W-1:0] left_key,
  input  logic [bsal_pkg::PAY_W-1:0] left_pay,
  input  logic [bsal_pkg::KEY_W-1:0] right_key,
  input  logic [bsal_pkg::PAY_W-1:0] right_pay,
  output logic [bsal_pkg::KEY_W-1:0] entry_key,
  output logic [bsal_pkg::PAY_W-1:0] entry_pay,
  output logic                       key_le
);

  // Flag an occupied entry whose key does not exceed the new key
  assign key_le = (CW'(IDX) < count) && (entry_key <= new_key);

  // Load the new record, or shift from a neighbor, or hold
  always_ff @(posedge clk) begin
    if (ctl.take_new) begin
      entry_key <= new_key;
      entry_pay <= new_pay;
    end else if (ctl.take_left) begin
      entry_key <= left_key;
      entry_pay <= left_pay;
    end else if (ctl.take_right) begin
      entry_key <= right_key;
      entry_pay <= right_pay;
    end
  end

endmodule

### hdl/bsal_scan.sv
module bsal_scan #(
  parameter int N = 16
) (
  input  logic [N-1:0] flags,
  output logic [N-1:0] suffix
);

  localparam int LV = $clog2(N);

  logic [N-1:0] lvl [LV+1];

  assign lvl[0] = flags;

  // Suffix OR: bit i is set when any flag at index i or above is set
  for (genvar l = 0; l < LV; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i + (1 << l) < N) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i + (1 << l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign suffix = lvl[LV];

endmodule

### hdl/bounded_sorted_array_list.sv
// Bounded list of up to DEPTH records (8-bit key, 32-bit payload) kept in a
// row of cells, positions 0 to entry_count-1. Every item is one operation:
// insert at front, at end, at a position (clamped to append) or in stable
// ascending key order; delete first, last or at a position; or read at a
// position. An insert into a full list reports status 1, a delete or read of
// an absent position reports status 2, and both leave the list unchanged.
// For each operation all cells compare and shift together, with
// the sorted insert point found by a log2(DEPTH)-level OR tree, so one item
// is accepted per cycle when in_stall is low; its result comes from an output
// register on the following cycle. in_stall is raised only while a result is
// held by out_stall. read_key and read_payload are zero except for a good read.
module bounded_sorted_array_list #(
  parameter int DEPTH = bsal_pkg::DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 op,
  input  logic [CW-1:0]              position,
  input  logic [bsal_pkg::KEY_W-1:0] key,
  input  logic [bsal_pkg::PAY_W-1:0] payload,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [CW-1:0]              entry_count,
  output logic [bsal_pkg::KEY_W-1:0] read_key,
  output logic [bsal_pkg::PAY_W-1:0] read_payload
);

  bsal_pkg::op_e     opc;
  logic              accept;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              full;
  logic              is_ins;
  logic              is_sorted;
  logic              is_del;
  logic              is_read;
  logic              ins_ok;
  logic              del_ok;
  logic              read_ok;
  logic [CW-1:0]     ins_pos;
  logic [CW-1:0]     del_pos;
  bsal_pkg::status_e st_next;

  logic [bsal_pkg::KEY_W-1:0] ek [DEPTH];
  logic [bsal_pkg::PAY_W-1:0] ep [DEPTH];
  logic [DEPTH-1:0]           le;
  logic [DEPTH-1:0]           suf;
  logic [bsal_pkg::KEY_W-1:0] rk;
  logic [bsal_pkg::PAY_W-1:0] rp;

  bsal_pkg::status_e st;

  assign opc      = bsal_pkg::op_e'(op);
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(DEPTH));

  // Decode the operation into class and target position
  always_comb begin
    is_ins    = 1'b0;
    is_sorted = 1'b0;
    is_del    = 1'b0;
    is_read   = 1'b0;
    ins_pos   = '0;
    del_pos   = '0;
    unique case (opc)
      bsal_pkg::OP_INS_FRONT: begin
        is_ins = 1'b1;
      end
      bsal_pkg::OP_INS_LAST: begin
        is_ins  = 1'b1;
        ins_pos = count;
      end
      bsal_pkg::OP_INS_AT: begin
        is_ins  = 1'b1;
        ins_pos = (position > count) ? count : position;
      end
      bsal_pkg::OP_INS_SORTED: begin
        is_ins    = 1'b1;
        is_sorted = 1'b1;
      end
      bsal_pkg::OP_DEL_FIRST: begin
        is_del = 1'b1;
      end
      bsal_pkg::OP_DEL_LAST: begin
        is_del  = 1'b1;
        del_pos = count - CW'(1);
      end
      bsal_pkg::OP_DEL_AT: begin
        is_del  = 1'b1;
        del_pos = position;
      end
      bsal_pkg::OP_READ_AT: begin
        is_read = 1'b1;
      end
    endcase
  end

  // Qualify the operation against the current fill
  always_comb begin
    ins_ok  = accept && is_ins && !full;
    del_ok  = 1'b0;
    read_ok = 1'b0;
    if (is_del) begin
      if (opc == bsal_pkg::OP_DEL_AT) begin
        del_ok = accept && (position < count);
      end else begin
        del_ok = accept && (count != '0);
      end
    end
    if (is_read) begin
      read_ok = position < count;
    end
  end

  // Find the sorted insert point from the last entry not above the new key
  bsal_scan #(
    .N(DEPTH)
  ) u_scan (
    .flags  (le),
    .suffix (suf)
  );

  // Row of record cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bsal_pkg::cell_ctl_t        ctl;
    logic                       s_eq;
    logic                       s_gt;
    logic [bsal_pkg::KEY_W-1:0] lk;
    logic [bsal_pkg::PAY_W-1:0] lp;
    logic [bsal_pkg::KEY_W-1:0] rkn;
    logic [bsal_pkg::PAY_W-1:0] rpn;

    if (i == 0) begin : g_first
      assign s_eq = !suf[i];
      assign s_gt = 1'b0;
      assign lk   = ek[i];
      assign lp   = ep[i];
    end else begin : g_mid
      assign s_eq = !suf[i] && suf[i-1];
      assign s_gt = !suf[i-1];
      assign lk   = ek[i-1];
      assign lp   = ep[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rkn = ek[i];
      assign rpn = ep[i];
    end else begin : g_inner
      assign rkn = ek[i+1];
      assign rpn = ep[i+1];
    end

    // Insert opens a slot at the target, delete closes the slot at the target
    always_comb begin
      ctl.take_new   = ins_ok && (is_sorted ? s_eq : (CW'(i) == ins_pos));
      ctl.take_left  = ins_ok && (i != 0) && (is_sorted ? s_gt : (CW'(i) > ins_pos));
      ctl.take_right = del_ok && (i != DEPTH - 1) && (CW'(i) >= del_pos);
    end

    bsal_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .new_key   (key),
      .new_pay   (payload),
      .left_key  (lk),
      .left_pay  (lp),
      .right_key (rkn),
      .right_pay (rpn),
      .entry_key (ek[i]),
      .entry_pay (ep[i]),
      .key_le    (le[i])
    );
  end

  // Select the addressed entry for a read
  always_comb begin
    rk = '0;
    rp = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (read_ok && (CW'(i) == position)) begin
        rk = rk | ek[i];
        rp = rp | ep[i];
      end
    end
  end

  // Next fill count and status
  always_comb begin
    count_next = count;
    st_next    = bsal_pkg::ST_DONE;
    if (ins_ok) begin
      count_next = count + CW'(1);
    end else if (del_ok) begin
      count_next = count - CW'(1);
    end
    if (is_ins && full) begin
      st_next = bsal_pkg::ST_FULL;
    end else if ((is_del && !del_ok) || (is_read && !read_ok)) begin
      st_next = bsal_pkg::ST_ABSENT;
    end
  end

  // Advance the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st           <= st_next;
      entry_count  <= count_next;
      read_key     <= rk;
      read_payload <= rp;
    end
  end

  assign status = st;

endmodule
